### rtl/trapezoid_move_setpoint_generator_core_macros.svh
// assertion helpers used by tmsg_ctrl
`ifndef TRAPEZOID_MOVE_SETPOINT_GENERATOR_CORE_MACROS_SVH
`define TRAPEZOID_MOVE_SETPOINT_GENERATOR_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TMSG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmsg same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TMSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmsg next-cycle check failed");

`endif

### rtl/tmsg_pkg.sv
`default_nettype none
package tmsg_pkg;

  // fixed-point format of positions, velocities and times
  localparam int PosW  = 32;
  localparam int FracW = 16;

  // request opcodes
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_MOVE    = 3'd1;
  localparam logic [2:0] OP_STOP    = 3'd2;
  localparam logic [2:0] OP_TICK    = 3'd3;
  localparam logic [2:0] OP_TIMEOUT = 3'd4;

  // result events
  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_ACHIEVED = 2'd1;
  localparam logic [1:0] EV_UNREACH  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_VMAX = 3'd0;
  localparam logic [2:0] REG_AMAX = 3'd1;
  localparam logic [2:0] REG_FREQ = 3'd2;
  localparam logic [2:0] REG_PTOL = 3'd3;
  localparam logic [2:0] REG_VTOL = 3'd4;

  // divider operand selects
  localparam logic [1:0] DSEL_TA     = 2'd0;
  localparam logic [1:0] DSEL_TRI    = 2'd1;
  localparam logic [1:0] DSEL_CRUISE = 2'd2;
  localparam logic [1:0] DSEL_TICK   = 2'd3;

  typedef logic [4:0] uop_t;

  // datapath micro-ops
  localparam uop_t UOP_NONE        = 5'd0;
  localparam uop_t UOP_IN_LOAD     = 5'd1;
  localparam uop_t UOP_PLAN_INIT   = 5'd2;
  localparam uop_t UOP_TICK_INC    = 5'd3;
  localparam uop_t UOP_TA_LOAD     = 5'd4;
  localparam uop_t UOP_H_ACC       = 5'd5;
  localparam uop_t UOP_H_T         = 5'd6;
  localparam uop_t UOP_H_REM       = 5'd7;
  localparam uop_t UOP_MUL_AH      = 5'd8;
  localparam uop_t UOP_MUL_MH      = 5'd9;
  localparam uop_t UOP_DA_LOAD     = 5'd10;
  localparam uop_t UOP_TRI_ACC     = 5'd11;
  localparam uop_t UOP_PEAK_M      = 5'd12;
  localparam uop_t UOP_TRAP        = 5'd13;
  localparam uop_t UOP_CRUISE_LOAD = 5'd14;
  localparam uop_t UOP_TOTAL       = 5'd15;
  localparam uop_t UOP_T_LOAD      = 5'd16;
  localparam uop_t UOP_P_HALF      = 5'd17;
  localparam uop_t UOP_ACC_HALF    = 5'd18;
  localparam uop_t UOP_MUL_PK      = 5'd19;
  localparam uop_t UOP_P_SUM       = 5'd20;
  localparam uop_t UOP_P_TAIL      = 5'd21;
  localparam uop_t UOP_SP_CALC     = 5'd22;
  localparam uop_t UOP_SP_DEST     = 5'd23;
  localparam uop_t UOP_DEST_MEAS   = 5'd24;
  localparam uop_t UOP_OUT_LOAD    = 5'd25;

  typedef struct packed {
    logic [30:0] vmax;
    logic [30:0] amax;
    logic [16:0] freq;
    logic [30:0] ptol;
    logic [30:0] vtol;
  } cfg_t;

  typedef struct packed {
    uop_t       uop;
    logic       div_start;
    logic [1:0] div_sel;
    logic       sqrt_start;
    logic       out_sp_en;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       div_busy;
    logic       sqrt_busy;
    logic       da_ge;
    logic       dist_zero;
    logic       t_ge_total;
    logic       t_lt_accel;
    logic       t_lt_ac;
    logic       settled;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/tmsg_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle
module tmsg_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        short_mode,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient
);

  localparam logic [6:0] ShortIters = 7'd48;
  localparam logic [6:0] LongIters  = 7'd64;

  logic [63:0] q_r, q_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [32:0] sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sh       = {rem_r, q_r[63]};
    if (start) begin
      q_nxt    = short_mode ? {dividend[47:0], 16'd0} : dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = short_mode ? ShortIters : LongIters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = 32'(sh - {1'b0, den_r});
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh[31:0];
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

### rtl/tmsg_sqrt.sv
`default_nettype none
// floored integer square root, one result bit per cycle
module tmsg_sqrt (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] radicand,
  output logic             busy,
  output logic [31:0]      root
);

  localparam logic [5:0]  Iters    = 6'd32;
  localparam logic [63:0] FirstBit = 64'd1 << 62;

  logic [63:0] x_r, x_nxt;
  logic [63:0] r_r, r_nxt;
  logic [63:0] bit_r, bit_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] sum;

  always_comb begin
    x_nxt    = x_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sum      = r_r + bit_r;
    if (start) begin
      x_nxt    = radicand;
      r_nxt    = '0;
      bit_nxt  = FirstBit;
      cnt_nxt  = Iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (x_r >= sum) begin
        x_nxt = x_r - sum;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign busy = busy_r;
  assign root = r_r[31:0];

endmodule
`default_nettype wire

### rtl/tmsg_dp.sv
`default_nettype none
// profile datapath: move state, shared multiplier, divider and square root
module tmsg_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tmsg_pkg::cfg_t      cfg,
  input  wire tmsg_pkg::dp_cmd_t   cmd,
  output tmsg_pkg::dp_sts_t        sts,
  input  wire logic [2:0]          in_op,
  input  wire logic signed [31:0]  in_target_position,
  input  wire logic signed [31:0]  in_measured_position,
  input  wire logic signed [31:0]  in_measured_velocity,
  output logic signed [31:0]       out_setpoint
);

  // latched request
  logic [2:0]  op_r;
  logic [31:0] tgt_r, meas_r, vel_r;
  // move state
  logic [31:0] start_r, dest_r, dist_r, accel_r, cruise_r, peak_r, total_r, tick_r;
  logic        neg_r;
  // scratch
  logic [31:0] h_r, m_r, da_r, t_r, acc_r, p_r, sp_r, out_sp_r;

  logic [31:0] a_lim, v_lim, f_lim;
  logic [31:0] mx, my, mres;
  logic [63:0] prod;
  logic [63:0] div_dividend, div_q;
  logic [31:0] div_den, qsat, sq_root;
  logic        div_short, div_busy, sqrt_busy;
  logic [32:0] dx, dx_abs;
  logic [32:0] da2, ac_sum, p_sum, err, err_abs, vel_abs;
  logic [31:0] cr_num, tail, p_lim;
  logic [33:0] tot_sum;

  assign a_lim = (cfg.amax == '0) ? 32'd1 : {1'b0, cfg.amax};
  assign v_lim = (cfg.vmax == '0) ? 32'd1 : {1'b0, cfg.vmax};
  assign f_lim = (cfg.freq == '0) ? 32'd1 : {15'd0, cfg.freq};

  // shared q16.16 multiplier
  always_comb begin
    case (cmd.uop)
      tmsg_pkg::UOP_MUL_MH: begin
        mx = m_r;
        my = h_r;
      end
      tmsg_pkg::UOP_MUL_PK: begin
        mx = peak_r;
        my = t_r - accel_r;
      end
      default: begin
        mx = a_lim;
        my = h_r;
      end
    endcase
  end
  assign prod = mx * my;
  assign mres = (prod[63:48] != '0) ? '1 : prod[47:16];

  // divider operands
  assign cr_num = 32'({1'b0, dist_r} - da2);
  always_comb begin
    case (cmd.div_sel)
      tmsg_pkg::DSEL_TA: begin
        div_dividend = {16'd0, v_lim, 16'd0};
        div_den      = a_lim;
        div_short    = 1'b1;
      end
      tmsg_pkg::DSEL_TRI: begin
        div_dividend = {dist_r, 32'd0};
        div_den      = a_lim;
        div_short    = 1'b0;
      end
      tmsg_pkg::DSEL_CRUISE: begin
        div_dividend = {16'd0, cr_num, 16'd0};
        div_den      = v_lim;
        div_short    = 1'b1;
      end
      default: begin
        div_dividend = {16'd0, tick_r, 16'd0};
        div_den      = f_lim;
        div_short    = 1'b1;
      end
    endcase
  end

  tmsg_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cmd.div_start),
    .short_mode (div_short),
    .dividend   (div_dividend),
    .divisor    (div_den),
    .busy       (div_busy),
    .quotient   (div_q)
  );

  tmsg_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (div_q),
    .busy     (sqrt_busy),
    .root     (sq_root)
  );

  assign qsat = (div_q[63:32] != '0) ? '1 : div_q[31:0];

  assign dx      = {tgt_r[31], tgt_r} - {meas_r[31], meas_r};
  assign dx_abs  = dx[32] ? (33'd0 - dx) : dx;
  assign da2     = {da_r, 1'b0};
  assign ac_sum  = {1'b0, accel_r} + {1'b0, cruise_r};
  assign p_sum   = {1'b0, acc_r} + {1'b0, m_r};
  assign tot_sum = {1'b0, accel_r, 1'b0} + {2'd0, cruise_r};
  assign tail    = {1'b0, m_r[31:1]};
  assign p_lim   = (p_r > dist_r) ? dist_r : p_r;
  assign err     = {dest_r[31], dest_r} - {meas_r[31], meas_r};
  assign err_abs = err[32] ? (33'd0 - err) : err;
  assign vel_abs = vel_r[31] ? (33'd0 - {vel_r[31], vel_r}) : {1'b0, vel_r};

  always_comb begin
    sts.op         = op_r;
    sts.div_busy   = div_busy;
    sts.sqrt_busy  = sqrt_busy;
    sts.da_ge      = da2 >= {1'b0, dist_r};
    sts.dist_zero  = dist_r == '0;
    sts.t_ge_total = t_r >= total_r;
    sts.t_lt_accel = t_r < accel_r;
    sts.t_lt_ac    = {1'b0, t_r} < ac_sum;
    sts.settled    = (err_abs < {2'd0, cfg.ptol}) && (vel_abs < {2'd0, cfg.vtol});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      dest_r   <= '0;
      dist_r   <= '0;
      neg_r    <= 1'b0;
      accel_r  <= '0;
      cruise_r <= '0;
      peak_r   <= '0;
      total_r  <= '0;
      tick_r   <= '0;
    end else begin
      case (cmd.uop)
        tmsg_pkg::UOP_PLAN_INIT: begin
          start_r <= meas_r;
          dest_r  <= tgt_r;
          neg_r   <= dx[32];
          dist_r  <= dx_abs[31:0];
          tick_r  <= '0;
        end
        tmsg_pkg::UOP_TICK_INC: begin
          if (tick_r != '1) begin
            tick_r <= tick_r + 32'd1;
          end
        end
        tmsg_pkg::UOP_TA_LOAD:     accel_r <= qsat;
        tmsg_pkg::UOP_TRI_ACC: begin
          accel_r  <= sq_root;
          cruise_r <= '0;
        end
        tmsg_pkg::UOP_PEAK_M:      peak_r   <= m_r;
        tmsg_pkg::UOP_TRAP:        peak_r   <= v_lim;
        tmsg_pkg::UOP_CRUISE_LOAD: cruise_r <= qsat;
        tmsg_pkg::UOP_TOTAL:       total_r  <= (tot_sum[33:32] != '0) ? '1 : tot_sum[31:0];
        tmsg_pkg::UOP_DEST_MEAS:   dest_r   <= meas_r;
        default: ;
      endcase
    end
  end

  // scratch and request registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.uop)
      tmsg_pkg::UOP_IN_LOAD: begin
        op_r   <= in_op;
        tgt_r  <= in_target_position;
        meas_r <= in_measured_position;
        vel_r  <= in_measured_velocity;
      end
      tmsg_pkg::UOP_H_ACC:    h_r   <= accel_r;
      tmsg_pkg::UOP_H_T:      h_r   <= t_r;
      tmsg_pkg::UOP_H_REM:    h_r   <= total_r - t_r;
      tmsg_pkg::UOP_MUL_AH:   m_r   <= mres;
      tmsg_pkg::UOP_MUL_MH:   m_r   <= mres;
      tmsg_pkg::UOP_MUL_PK:   m_r   <= mres;
      tmsg_pkg::UOP_DA_LOAD:  da_r  <= tail;
      tmsg_pkg::UOP_T_LOAD:   t_r   <= qsat;
      tmsg_pkg::UOP_P_HALF:   p_r   <= tail;
      tmsg_pkg::UOP_ACC_HALF: acc_r <= tail;
      tmsg_pkg::UOP_P_SUM:    p_r   <= p_sum[32] ? '1 : p_sum[31:0];
      tmsg_pkg::UOP_P_TAIL:   p_r   <= (tail >= dist_r) ? '0 : (dist_r - tail);
      tmsg_pkg::UOP_SP_CALC:  sp_r  <= neg_r ? (start_r - p_lim) : (start_r + p_lim);
      tmsg_pkg::UOP_SP_DEST:  sp_r  <= dest_r;
      tmsg_pkg::UOP_OUT_LOAD: out_sp_r <= cmd.out_sp_en ? sp_r : '0;
      default: ;
    endcase
  end

  assign out_setpoint = out_sp_r;

endmodule
`default_nettype wire

### rtl/tmsg_ctrl.sv
`default_nettype none
`include "trapezoid_move_setpoint_generator_core_macros.svh"
// request sequencer: move flags, micro-op issue, result register handshake
module tmsg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_setpoint_valid,
  output logic [1:0]             out_event_res,
  output tmsg_pkg::dp_cmd_t      cmd,
  input  wire tmsg_pkg::dp_sts_t sts
);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DECODE   = 5'd1;
  localparam logic [4:0] ST_P_INIT   = 5'd2;
  localparam logic [4:0] ST_P_DIV_TA = 5'd3;
  localparam logic [4:0] ST_P_HSET   = 5'd4;
  localparam logic [4:0] ST_H_M1     = 5'd5;
  localparam logic [4:0] ST_H_M2     = 5'd6;
  localparam logic [4:0] ST_H_END    = 5'd7;
  localparam logic [4:0] ST_P_CMP    = 5'd8;
  localparam logic [4:0] ST_P_DIVTRI = 5'd9;
  localparam logic [4:0] ST_P_SQRT   = 5'd10;
  localparam logic [4:0] ST_P_PKH    = 5'd11;
  localparam logic [4:0] ST_P_PKM    = 5'd12;
  localparam logic [4:0] ST_P_PK     = 5'd13;
  localparam logic [4:0] ST_P_DIV_CR = 5'd14;
  localparam logic [4:0] ST_P_TOTAL  = 5'd15;
  localparam logic [4:0] ST_T_DIV    = 5'd16;
  localparam logic [4:0] ST_T_WAIT   = 5'd17;
  localparam logic [4:0] ST_T_SEG    = 5'd18;
  localparam logic [4:0] ST_S2_MUL   = 5'd19;
  localparam logic [4:0] ST_S2_SUM   = 5'd20;
  localparam logic [4:0] ST_SP       = 5'd21;
  localparam logic [4:0] ST_CHECK    = 5'd22;
  localparam logic [4:0] ST_DONE     = 5'd23;

  // who called the half a*t*t routine
  localparam logic [1:0] CTX_DA   = 2'd0;
  localparam logic [1:0] CTX_SEG1 = 2'd1;
  localparam logic [1:0] CTX_SEG2 = 2'd2;
  localparam logic [1:0] CTX_SEG3 = 2'd3;

  logic [4:0] state_r, state_nxt;
  logic [1:0] ctx_r, ctx_nxt;
  logic       operating_r, operating_nxt;
  logic       pending_r, pending_nxt;
  logic       active_r, active_nxt;
  logic       res_valid_r, res_valid_nxt;
  logic [1:0] res_ev_r, res_ev_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_spv_r, out_spv_nxt;
  logic [1:0] out_ev_r, out_ev_nxt;

  always_comb begin
    state_nxt     = state_r;
    ctx_nxt       = ctx_r;
    operating_nxt = operating_r;
    pending_nxt   = pending_r;
    active_nxt    = active_r;
    res_valid_nxt = res_valid_r;
    res_ev_nxt    = res_ev_r;
    out_spv_nxt   = out_spv_r;
    out_ev_nxt    = out_ev_r;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.uop = tmsg_pkg::UOP_IN_LOAD;
        if (in_valid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_valid_nxt = 1'b0;
        res_ev_nxt    = tmsg_pkg::EV_NONE;
        state_nxt     = ST_DONE;
        case (sts.op)
          tmsg_pkg::OP_START: begin
            if (!operating_r) begin
              operating_nxt = 1'b1;
              state_nxt     = ST_P_INIT;
            end
          end
          tmsg_pkg::OP_MOVE: begin
            if (operating_r) begin
              state_nxt = ST_P_INIT;
            end
          end
          tmsg_pkg::OP_STOP: begin
            if (operating_r) begin
              operating_nxt = 1'b0;
              pending_nxt   = 1'b0;
              active_nxt    = 1'b0;
            end
          end
          tmsg_pkg::OP_TICK: begin
            if (operating_r) begin
              if (pending_r && active_r) begin
                cmd.uop   = tmsg_pkg::UOP_TICK_INC;
                state_nxt = ST_T_DIV;
              end else begin
                cmd.uop   = tmsg_pkg::UOP_SP_DEST;
                state_nxt = ST_CHECK;
              end
            end
          end
          tmsg_pkg::OP_TIMEOUT: begin
            if (operating_r && pending_r) begin
              pending_nxt = 1'b0;
              active_nxt  = 1'b0;
              res_ev_nxt  = tmsg_pkg::EV_UNREACH;
              cmd.uop     = tmsg_pkg::UOP_DEST_MEAS;
            end
          end
          default: ;
        endcase
      end
      // planning
      ST_P_INIT: begin
        cmd.uop       = tmsg_pkg::UOP_PLAN_INIT;
        cmd.div_start = 1'b1;
        cmd.div_sel   = tmsg_pkg::DSEL_TA;
        state_nxt     = ST_P_DIV_TA;
      end
      ST_P_DIV_TA: begin
        if (!sts.div_busy) begin
          cmd.uop   = tmsg_pkg::UOP_TA_LOAD;
          state_nxt = ST_P_HSET;
        end
      end
      ST_P_HSET: begin
        cmd.uop   = tmsg_pkg::UOP_H_ACC;
        ctx_nxt   = CTX_DA;
        state_nxt = ST_H_M1;
      end
      ST_H_M1: begin
        cmd.uop   = tmsg_pkg::UOP_MUL_AH;
        state_nxt = ST_H_M2;
      end
      ST_H_M2: begin
        cmd.uop   = tmsg_pkg::UOP_MUL_MH;
        state_nxt = ST_H_END;
      end
      ST_H_END: begin
        case (ctx_r)
          CTX_DA: begin
            cmd.uop   = tmsg_pkg::UOP_DA_LOAD;
            state_nxt = ST_P_CMP;
          end
          CTX_SEG1: begin
            cmd.uop   = tmsg_pkg::UOP_P_HALF;
            state_nxt = ST_SP;
          end
          CTX_SEG2: begin
            cmd.uop   = tmsg_pkg::UOP_ACC_HALF;
            state_nxt = ST_S2_MUL;
          end
          default: begin
            cmd.uop   = tmsg_pkg::UOP_P_TAIL;
            state_nxt = ST_SP;
          end
        endcase
      end
      ST_P_CMP: begin
        cmd.div_start = 1'b1;
        if (sts.da_ge) begin
          cmd.div_sel = tmsg_pkg::DSEL_TRI;
          state_nxt   = ST_P_DIVTRI;
        end else begin
          cmd.uop     = tmsg_pkg::UOP_TRAP;
          cmd.div_sel = tmsg_pkg::DSEL_CRUISE;
          state_nxt   = ST_P_DIV_CR;
        end
      end
      ST_P_DIVTRI: begin
        if (!sts.div_busy) begin
          cmd.sqrt_start = 1'b1;
          state_nxt      = ST_P_SQRT;
        end
      end
      ST_P_SQRT: begin
        if (!sts.sqrt_busy) begin
          cmd.uop   = tmsg_pkg::UOP_TRI_ACC;
          state_nxt = ST_P_PKH;
        end
      end
      ST_P_PKH: begin
        cmd.uop   = tmsg_pkg::UOP_H_ACC;
        state_nxt = ST_P_PKM;
      end
      ST_P_PKM: begin
        cmd.uop   = tmsg_pkg::UOP_MUL_AH;
        state_nxt = ST_P_PK;
      end
      ST_P_PK: begin
        cmd.uop   = tmsg_pkg::UOP_PEAK_M;
        state_nxt = ST_P_TOTAL;
      end
      ST_P_DIV_CR: begin
        if (!sts.div_busy) begin
          cmd.uop   = tmsg_pkg::UOP_CRUISE_LOAD;
          state_nxt = ST_P_TOTAL;
        end
      end
      ST_P_TOTAL: begin
        cmd.uop     = tmsg_pkg::UOP_TOTAL;
        pending_nxt = 1'b1;
        active_nxt  = 1'b1;
        state_nxt   = ST_DONE;
      end
      // setpoint tick
      ST_T_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tmsg_pkg::DSEL_TICK;
        state_nxt     = ST_T_WAIT;
      end
      ST_T_WAIT: begin
        if (!sts.div_busy) begin
          cmd.uop   = tmsg_pkg::UOP_T_LOAD;
          state_nxt = ST_T_SEG;
        end
      end
      ST_T_SEG: begin
        state_nxt = ST_H_M1;
        if (sts.dist_zero || sts.t_ge_total) begin
          cmd.uop    = tmsg_pkg::UOP_SP_DEST;
          active_nxt = 1'b0;
          state_nxt  = ST_CHECK;
        end else if (sts.t_lt_accel) begin
          cmd.uop = tmsg_pkg::UOP_H_T;
          ctx_nxt = CTX_SEG1;
        end else if (sts.t_lt_ac) begin
          cmd.uop = tmsg_pkg::UOP_H_ACC;
          ctx_nxt = CTX_SEG2;
        end else begin
          cmd.uop = tmsg_pkg::UOP_H_REM;
          ctx_nxt = CTX_SEG3;
        end
      end
      ST_S2_MUL: begin
        cmd.uop   = tmsg_pkg::UOP_MUL_PK;
        state_nxt = ST_S2_SUM;
      end
      ST_S2_SUM: begin
        cmd.uop   = tmsg_pkg::UOP_P_SUM;
        state_nxt = ST_SP;
      end
      ST_SP: begin
        cmd.uop   = tmsg_pkg::UOP_SP_CALC;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        res_valid_nxt = 1'b1;
        if (pending_r && sts.settled) begin
          pending_nxt = 1'b0;
          active_nxt  = 1'b0;
          res_ev_nxt  = tmsg_pkg::EV_ACHIEVED;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.uop       = tmsg_pkg::UOP_OUT_LOAD;
          cmd.out_sp_en = res_valid_r;
          out_valid_nxt = 1'b1;
          out_spv_nxt   = res_valid_r;
          out_ev_nxt    = res_ev_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctx_r       <= CTX_DA;
      operating_r <= 1'b0;
      pending_r   <= 1'b0;
      active_r    <= 1'b0;
      res_valid_r <= 1'b0;
      res_ev_r    <= tmsg_pkg::EV_NONE;
      out_valid_r <= 1'b0;
      out_spv_r   <= 1'b0;
      out_ev_r    <= tmsg_pkg::EV_NONE;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      operating_r <= operating_nxt;
      pending_r   <= pending_nxt;
      active_r    <= active_nxt;
      res_valid_r <= res_valid_nxt;
      res_ev_r    <= res_ev_nxt;
      out_valid_r <= out_valid_nxt;
      out_spv_r   <= out_spv_nxt;
      out_ev_r    <= out_ev_nxt;
    end
  end

  assign in_stall           = state_r != ST_IDLE;
  assign out_valid          = out_valid_r;
  assign out_setpoint_valid = out_spv_r;
  assign out_event_res      = out_ev_r;

  `TMSG_ASSERT_SAME(a_active_has_pending, active_r, pending_r)
  `TMSG_ASSERT_SAME(a_pending_has_oper, pending_r, operating_r)
  `TMSG_ASSERT_SAME(a_achieved_on_tick, out_valid_r && (out_ev_r == tmsg_pkg::EV_ACHIEVED), out_spv_r)
  `TMSG_ASSERT_SAME(a_unreach_no_sp, out_valid_r && (out_ev_r == tmsg_pkg::EV_UNREACH), !out_spv_r)
  `TMSG_ASSERT_NEXT(a_accept_then_busy, in_valid && !in_stall, in_stall)

endmodule
`default_nettype wire

### rtl/trapezoid_move_setpoint_generator_core.sv
// one request at a time: a new request is taken only once the last result is in the output register
// a tick during a profile runs one division on the shared divider; other ticks run none
// start or move: a cruise plan runs two short divisions, a triangle plan a short and a long
//   division and then the square root
// stop, timeout and ignored requests run no division; results wait in an output register
// synchronous active-low reset clears flags and handshake, loads register defaults
`default_nettype none
module trapezoid_move_setpoint_generator_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [31:0] in_target_position,
  input  wire logic signed [31:0] in_measured_position,
  input  wire logic signed [31:0] in_measured_velocity,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_setpoint,
  output logic                    out_setpoint_valid,
  output logic [1:0]              out_event_res,
  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  tmsg_pkg::cfg_t    cfg_r, cfg_nxt;
  tmsg_pkg::dp_cmd_t cmd;
  tmsg_pkg::dp_sts_t sts;
  logic              wr_en;
  logic [2:0]        reg_idx;

  // register file: word index from the byte address
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        tmsg_pkg::REG_VMAX: cfg_nxt.vmax = pwdata[30:0];
        tmsg_pkg::REG_AMAX: cfg_nxt.amax = pwdata[30:0];
        tmsg_pkg::REG_FREQ: cfg_nxt.freq = pwdata[16:0];
        tmsg_pkg::REG_PTOL: cfg_nxt.ptol = pwdata[30:0];
        tmsg_pkg::REG_VTOL: cfg_nxt.vtol = pwdata[30:0];
        default: ;
      endcase
    end
  end

  // register readback, unused addresses read zero
  always_comb begin
    case (reg_idx)
      tmsg_pkg::REG_VMAX: prdata = {1'b0, cfg_r.vmax};
      tmsg_pkg::REG_AMAX: prdata = {1'b0, cfg_r.amax};
      tmsg_pkg::REG_FREQ: prdata = {15'd0, cfg_r.freq};
      tmsg_pkg::REG_PTOL: prdata = {1'b0, cfg_r.ptol};
      tmsg_pkg::REG_VTOL: prdata = {1'b0, cfg_r.vtol};
      default:            prdata = '0;
    endcase
  end

  // defaults: 1.0 unit/s, 1.0 unit/s^2, 1 khz ticks, about 0.01 unit tolerances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vmax <= 31'd65536;
      cfg_r.amax <= 31'd65536;
      cfg_r.freq <= 17'd1000;
      cfg_r.ptol <= 31'd655;
      cfg_r.vtol <= 31'd655;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // sequencer: owns operating / pending / profile flags and the result handshake
  tmsg_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_setpoint_valid (out_setpoint_valid),
    .out_event_res      (out_event_res),
    .cmd                (cmd),
    .sts                (sts)
  );

  // datapath: plan registers, shared multiplier, divider and square root
  tmsg_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_op),
    .in_target_position   (in_target_position),
    .in_measured_position (in_measured_position),
    .in_measured_velocity (in_measured_velocity),
    .out_setpoint         (out_setpoint)
  );

endmodule
`default_nettype wire

### tb/sv/tb_trapezoid_move_setpoint_generator_core.sv
`default_nettype none
module tb_trapezoid_move_setpoint_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  // op codes the block must ignore
  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  localparam logic [63:0] SAT_MAX = 64'h0000_0000_FFFF_FFFF;
  localparam int          N_PHASES = 6;
  localparam int          N_RANDOM = 288;
  localparam int          N_DIRECTED = 25;

  typedef struct packed {
    logic [31:0] sp;
    logic        sp_ok;
    logic [1:0]  ev;
  } outcome_t;

  // one row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] tgt;
    logic [31:0] meas;
    logic [31:0] vel;
    logic        fixed;
    outcome_t    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_op = tmsg_pkg::OP_STOP;
  logic signed [31:0] in_target_position = '0;
  logic signed [31:0] in_measured_position = '0;
  logic signed [31:0] in_measured_velocity = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_setpoint;
  logic               out_setpoint_valid;
  logic [1:0]         out_event_res;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  trapezoid_move_setpoint_generator_core u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_target_position   (in_target_position),
    .in_measured_position (in_measured_position),
    .in_measured_velocity (in_measured_velocity),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_setpoint         (out_setpoint),
    .out_setpoint_valid   (out_setpoint_valid),
    .out_event_res        (out_event_res),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // profile predictor: own copy of limits and motion state
  // ---------------------------------------------------------------------
  logic [63:0] vel_limit = 64'd65536;
  logic [63:0] acc_limit = 64'd65536;
  logic [63:0] tick_rate = 64'd1000;
  logic [63:0] pos_tol   = 64'd655;
  logic [63:0] vel_tol   = 64'd655;

  bit          running, move_open, ramp_live, heading_down;
  longint      origin_pos, dest_pos;
  logic [63:0] span, ramp_t, coast_t, top_speed, profile_t, tick_cnt;

  outcome_t    pending_results[$];
  int unsigned mismatches = 0;
  bit          calm = 1'b0;   // no idling on either side while set

  function automatic logic [63:0] clip32(input logic [63:0] x);
    return (x > SAT_MAX) ? SAT_MAX : x;
  endfunction

  // unsigned q16.16 product, saturating
  function automatic logic [63:0] qmul(input logic [63:0] x, input logic [63:0] y);
    return clip32((clip32(x) * clip32(y)) >> 16);
  endfunction

  // distance covered from rest: a*t*t/2
  function automatic logic [63:0] ramp_dist(input logic [63:0] a, input logic [63:0] t);
    return qmul(qmul(a, t), t) >> 1;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] nz(input logic [63:0] x);
    return (x == 0) ? 64'd1 : x;
  endfunction

  function automatic void plan_profile(input logic signed [31:0] tgt,
                                       input logic signed [31:0] meas);
    logic [63:0] a, v, ta, da;
    longint      dx;
    a = nz(acc_limit);
    v = nz(vel_limit);
    dx = longint'(tgt) - longint'(meas);
    origin_pos = longint'(meas);
    dest_pos = longint'(tgt);
    heading_down = dx < 0;
    span = heading_down ? 64'(-dx) : 64'(dx);
    ta = clip32((v << 16) / a);
    da = ramp_dist(a, ta);
    if (2 * da >= span) begin
      // too short to reach full speed: triangle
      ramp_t = clip32(int_sqrt((span << 32) / a));
      coast_t = '0;
      top_speed = qmul(a, ramp_t);
    end else begin
      ramp_t = ta;
      top_speed = v;
      coast_t = clip32(((span - 2 * da) << 16) / v);
    end
    profile_t = clip32(2 * ramp_t + coast_t);
    move_open = 1'b1;
    ramp_live = 1'b1;
    tick_cnt = '0;
  endfunction

  function automatic longint profile_pos();
    logic [63:0] t, p, tail;
    t = clip32((tick_cnt << 16) / nz(tick_rate));
    if (span == 0 || t >= profile_t) begin
      ramp_live = 1'b0;
      return dest_pos;
    end
    if (t < ramp_t) begin
      p = ramp_dist(nz(acc_limit), t);
    end else if (t < ramp_t + coast_t) begin
      p = clip32(ramp_dist(nz(acc_limit), ramp_t) + qmul(top_speed, t - ramp_t));
    end else begin
      tail = ramp_dist(nz(acc_limit), profile_t - t);
      p = (tail >= span) ? 64'd0 : span - tail;
    end
    if (p > span) p = span;
    return heading_down ? origin_pos - longint'(p) : origin_pos + longint'(p);
  endfunction

  function automatic outcome_t step_profile(input logic [2:0] op,
                                            input logic signed [31:0] tgt,
                                            input logic signed [31:0] meas,
                                            input logic signed [31:0] vel);
    outcome_t    res;
    longint      sp, err, sv;
    logic [63:0] pos_err, speed;
    res = '0;
    sp = 0;
    case (op)
      tmsg_pkg::OP_START: begin
        if (!running) begin
          running = 1'b1;
          plan_profile(tgt, meas);
        end
      end
      tmsg_pkg::OP_MOVE: begin
        if (running) plan_profile(tgt, meas);
      end
      tmsg_pkg::OP_STOP: begin
        if (running) begin
          running = 1'b0;
          move_open = 1'b0;
          ramp_live = 1'b0;
        end
      end
      tmsg_pkg::OP_TICK: begin
        if (running) begin
          if (move_open && ramp_live) begin
            if (tick_cnt < SAT_MAX) tick_cnt = tick_cnt + 1;
            sp = profile_pos();
          end else begin
            sp = dest_pos;
          end
          res.sp_ok = 1'b1;
          if (move_open) begin
            err = dest_pos - longint'(meas);
            sv = longint'(vel);
            pos_err = (err < 0) ? 64'(-err) : 64'(err);
            speed = (sv < 0) ? 64'(-sv) : 64'(sv);
            // settled: both inside tolerance
            if (pos_err < pos_tol && speed < vel_tol) begin
              move_open = 1'b0;
              ramp_live = 1'b0;
              res.ev = tmsg_pkg::EV_ACHIEVED;
            end
          end
        end
      end
      tmsg_pkg::OP_TIMEOUT: begin
        if (running && move_open) begin
          move_open = 1'b0;
          ramp_live = 1'b0;
          dest_pos = longint'(meas);
          res.ev = tmsg_pkg::EV_UNREACH;
        end
      end
      default: ;
    endcase
    res.sp = sp[31:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  int unsigned stall_left = 0;

  // result-side back pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall = 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------
  function automatic void flag(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (mismatches < 10)
      $display("%0t mismatch %s: expected %h got %h", $realtime, what, want, got);
    mismatches = mismatches + 1;
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag("result with nothing pending", '0, out_setpoint);
      end else begin
        want = pending_results.pop_front();
        if (out_setpoint !== want.sp) flag("setpoint", want.sp, out_setpoint);
        if (out_setpoint_valid !== want.sp_ok)
          flag("setpoint_valid", 32'(want.sp_ok), 32'(out_setpoint_valid));
        if (out_event_res !== want.ev)
          flag("event", 32'(want.ev), 32'(out_event_res));
      end
    end
  end

  // ---------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------
  task automatic send_request(input logic [2:0] op, input logic [31:0] tgt,
                              input logic [31:0] meas, input logic [31:0] vel,
                              input bit fixed, input outcome_t want);
    int unsigned gap;
    outcome_t    pred;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_op = op;
    in_target_position = tgt;
    in_measured_position = meas;
    in_measured_velocity = vel;
    do @(posedge clk); while (in_stall);
    // request taken at this edge
    pred = step_profile(op, tgt, meas, vel);
    pending_results.push_back(fixed ? want : pred);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // setup then access; register is written on the access edge, then read back
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    mask = (idx == tmsg_pkg::REG_FREQ) ? 32'h0001_FFFF : 32'h7FFF_FFFF;
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask)) flag("register readback", value & mask, prdata);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    case (idx)
      tmsg_pkg::REG_VMAX: vel_limit = 64'(value & mask);
      tmsg_pkg::REG_AMAX: acc_limit = 64'(value & mask);
      tmsg_pkg::REG_FREQ: tick_rate = 64'(value & mask);
      tmsg_pkg::REG_PTOL: pos_tol = 64'(value & mask);
      tmsg_pkg::REG_VTOL: vel_tol = 64'(value & mask);
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------
  // directed table, walked with the reset limits
  // ---------------------------------------------------------------------
  localparam outcome_t QUIET = '0;

  dir_row_t directed [N_DIRECTED] = '{
    // tick, stop, timeout, move and a junk op while idle: all ignored
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_STOP,    32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_TIMEOUT, 32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_MOVE,    32'h0010_0000, 32'h0, 32'h0, 1'b1, QUIET},
    '{OP_BAD7,              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, QUIET},
    // longest possible move
    '{tmsg_pkg::OP_START,   32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0, 32'h8000_0000, 1'b0, QUIET},
    // start while running is dropped
    '{tmsg_pkg::OP_START,   32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    // zero-length move settles at once
    '{tmsg_pkg::OP_MOVE,    32'h0005_0000, 32'h0005_0000, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0005_0000, 32'h0, 1'b1,
      '{32'h0005_0000, 1'b1, tmsg_pkg::EV_ACHIEVED}},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1,
      '{32'h0005_0000, 1'b1, tmsg_pkg::EV_NONE}},
    // timeout with no open move
    '{tmsg_pkg::OP_TIMEOUT, 32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_MOVE,    32'h8000_0000, 32'h0001_0000, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0, 32'h0, 1'b0, QUIET},
    // abort: measured position becomes the held destination
    '{tmsg_pkg::OP_TIMEOUT, 32'h0, 32'h1234_5678, 32'h0, 1'b1,
      '{32'h0, 1'b0, tmsg_pkg::EV_UNREACH}},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0, 32'h0, 1'b1,
      '{32'h1234_5678, 1'b1, tmsg_pkg::EV_NONE}},
    '{tmsg_pkg::OP_STOP,    32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    '{OP_BAD5,              32'h0, 32'h0, 32'h0, 1'b1, QUIET},
    // short move in the negative direction
    '{tmsg_pkg::OP_START,   32'hFFFF_0000, 32'h0002_0000, 32'h0, 1'b1, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0002_0000, 32'h0001_0000, 1'b0, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0001_0000, 32'hFFFF_0000, 1'b0, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'h0, 32'h0, 1'b0, QUIET},
    '{tmsg_pkg::OP_TICK,    32'h0, 32'hFFFF_0100, 32'hFFFF_FF00, 1'b0, QUIET}
  };

  // limit sets per random phase: vmax, amax, freq, ptol, vtol
  logic [31:0] limits [N_PHASES][5] = '{
    '{32'h0002_0000, 32'h0004_0000, 32'd10,     32'h0000_8000, 32'h0000_8000},
    '{32'h0000_0001, 32'h0000_0001, 32'd1,      32'h0,         32'h0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd100000, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
    '{32'h0,         32'h0,         32'h0,      32'd655,       32'd655},
    '{32'h0004_0000, 32'h0001_0000, 32'd1,      32'h0001_0000, 32'h0004_0000},
    '{32'h0012_3456, 32'h0000_7FFF, 32'd50,     32'h0000_1000, 32'h0000_2000}
  };

  function automatic logic [31:0] near(input longint base, input int unsigned spread);
    return 32'(base + longint'($urandom_range(0, 2 * spread)) - longint'(spread));
  endfunction

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    logic [2:0]  op;
    logic [31:0] tgt, meas, vel;
    int unsigned r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      send_request(directed[i].op, directed[i].tgt, directed[i].meas, directed[i].vel,
                   directed[i].fixed, directed[i].want);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      reg_write(tmsg_pkg::REG_VMAX, limits[ph][0]);
      reg_write(tmsg_pkg::REG_AMAX, limits[ph][1]);
      reg_write(tmsg_pkg::REG_FREQ, limits[ph][2]);
      reg_write(tmsg_pkg::REG_PTOL, limits[ph][3]);
      reg_write(tmsg_pkg::REG_VTOL, limits[ph][4]);
      for (int n = 0; n < N_RANDOM; n++) begin
        if (n % 96 == 0) calm = ($urandom_range(0, 3) == 0);
        r = $urandom_range(0, 99);
        if (!running && r < 70) op = tmsg_pkg::OP_START;
        else if (r < 60) op = tmsg_pkg::OP_TICK;
        else if (r < 68) op = tmsg_pkg::OP_MOVE;
        else if (r < 74) op = tmsg_pkg::OP_START;
        else if (r < 80) op = tmsg_pkg::OP_STOP;
        else if (r < 87) op = tmsg_pkg::OP_TIMEOUT;
        else if (r < 90) op = 3'($urandom_range(OP_BAD5, OP_BAD7));
        else op = tmsg_pkg::OP_TICK;
        // measured position mostly close to the held destination
        r = $urandom_range(0, 9);
        if (r < 4) meas = near(dest_pos, 512);
        else if (r < 7) meas = near(dest_pos, 32'h0001_0000);
        else meas = $urandom;
        vel = ($urandom_range(0, 1) == 0) ? near(0, 512) : $urandom;
        // mostly short moves so that profiles run to their end
        if ($urandom_range(0, 9) < 7) tgt = near(longint'($signed(meas)), 32'h0002_0000);
        else tgt = $urandom;
        send_request(op, tgt, meas, vel, 1'b0, QUIET);
      end
    end
    calm = 1'b0;
    drain();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb_trapezoid_move_setpoint_generator_core: clean");
    end else begin
      $display("tb_trapezoid_move_setpoint_generator_core: errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("tb_trapezoid_move_setpoint_generator_core: errors");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/tmsg_pkg.sv
rtl/tmsg_div.sv
rtl/tmsg_sqrt.sv
rtl/tmsg_dp.sv
rtl/tmsg_ctrl.sv
rtl/trapezoid_move_setpoint_generator_core.sv
tb/sv/tb_trapezoid_move_setpoint_generator_core.sv
